>>> hdl/bsc_pkg.sv
`timescale 1ns / 1ps

package bsc_pkg;

    // divider depth, one quotient bit per stage
    localparam int DIV_STEPS = 32;
    // cycles from an accepted start to the result strobe
    localparam int LATENCY   = 80;

    // configuration register indexes
    localparam logic [1:0] REG_OSS   = 2'd0;
    localparam logic [1:0] REG_CAL_A = 2'd1;
    localparam logic [1:0] REG_CAL_B = 2'd2;
    localparam logic [1:0] REG_CAL_C = 2'd3;

    // compensation constants
    localparam logic [31:0] C_TEMP_OFS  = 32'd4000;
    localparam logic [31:0] C_TEMP_RND  = 32'd8;
    localparam logic [31:0] C_B4_OFS    = 32'd32768;
    localparam logic [31:0] C_B7_SCALE  = 32'd50000;
    localparam logic [31:0] C_P_K1      = 32'd3038;
    localparam logic [31:0] C_P_K2      = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] C_P_K3      = 32'd3791;

    // decoded calibration words, each widened to 32 bits, and the 2-bit oss field
    typedef struct packed {
        logic [31:0] ac1;
        logic [31:0] ac2;
        logic [31:0] ac3;
        logic [31:0] ac4;
        logic [31:0] ac5;
        logic [31:0] ac6;
        logic [31:0] b1;
        logic [31:0] b2;
        logic [31:0] mc;
        logic [31:0] md;
        logic [1:0]  oss;
    } t_cal;

    // beat handed from the temperature path to the pressure path
    typedef struct packed {
        logic        vld;
        logic        fault;
        logic [31:0] b5;
        logic [23:0] up;
    } t_tbeat;

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
        asr = $unsigned($signed(v) >>> s);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] zx16(input logic [15:0] v);
        zx16 = {16'd0, v};
    endfunction

endpackage

>>> hdl/barometric_sensor_compensation.sv
`timescale 1ns / 1ps

// channel   direction  ports
// command   in         i_start, o_busy, i_raw_temperature, i_raw_pressure_bytes
// result    out        o_valid, o_temperature_tenths, o_pressure_pa, o_divide_fault
// config    in         i_cfg_we, i_cfg_idx, i_cfg_data
//
// one reading pair per cycle; each reading passes the two 32-stage restoring
// dividers in series. o_busy is always low; the pipeline has no stalls. the
// receiver must take every result beat, which the block does not enforce.
// synchronous reset clears the valid line and calibration, and sets oss to 3

module barometric_sensor_compensation
    import bsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [15:0] i_raw_temperature,
    input  logic [23:0] i_raw_pressure_bytes,
    output logic        o_valid,
    output logic signed [15:0] o_temperature_tenths,
    output logic [31:0] o_pressure_pa,
    output logic        o_divide_fault,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    logic [1:0]  r_oss;
    logic [63:0] r_cal_a, r_cal_b;
    logic [31:0] r_cal_c;
    t_cal        w_cal;
    t_tbeat      w_beat;
    logic [15:0] w_temp;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oss   <= 2'd3;
            r_cal_a <= 64'd0;
            r_cal_b <= 64'd0;
            r_cal_c <= 32'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_OSS:   r_oss   <= i_cfg_data[1:0];
                REG_CAL_A: r_cal_a <= i_cfg_data;
                REG_CAL_B: r_cal_b <= i_cfg_data;
                REG_CAL_C: r_cal_c <= i_cfg_data[31:0];
                default:   r_oss   <= r_oss;
            endcase
        end
    end

    // calibration word decode
    always_comb begin
        w_cal.ac1 = sx16(r_cal_a[63:48]);
        w_cal.ac2 = sx16(r_cal_a[47:32]);
        w_cal.ac3 = sx16(r_cal_a[31:16]);
        w_cal.ac4 = zx16(r_cal_a[15:0]);
        w_cal.ac5 = zx16(r_cal_b[63:48]);
        w_cal.ac6 = zx16(r_cal_b[47:32]);
        w_cal.b1  = sx16(r_cal_b[31:16]);
        w_cal.b2  = sx16(r_cal_b[15:0]);
        w_cal.mc  = sx16(r_cal_c[31:16]);
        w_cal.md  = sx16(r_cal_c[15:0]);
        w_cal.oss = r_oss;
    end

    assign o_busy = 1'b0;

    bsc_temp u_temp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cal    (w_cal),
        .i_vld    (i_start & ~o_busy),
        .i_ut     (i_raw_temperature),
        .i_up_raw (i_raw_pressure_bytes),
        .o_beat   (w_beat)
    );

    bsc_press u_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cal   (w_cal),
        .i_beat  (w_beat),
        .o_valid (o_valid),
        .o_temp  (w_temp),
        .o_pres  (o_pressure_pa),
        .o_fault (o_divide_fault)
    );

    assign o_temperature_tenths = $signed(w_temp);

endmodule

>>> hdl/bsc_div.sv
`timescale 1ns / 1ps

module bsc_div
    import bsc_pkg::*;
(
    input  logic        i_clk,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic [31:0] o_quo
);

    logic [31:0] r_rem [DIV_STEPS];
    logic [31:0] r_quo [DIV_STEPS];
    logic [31:0] r_den [DIV_STEPS];
    logic [31:0] n_rem [DIV_STEPS];
    logic [31:0] n_quo [DIV_STEPS];
    logic [31:0] n_den [DIV_STEPS];

    // one restoring step per stage
    always_comb begin
        logic [31:0] rem_in;
        logic [31:0] quo_in;
        logic [31:0] den_in;
        logic [32:0] sh;
        logic [32:0] diff;
        for (int k = 0; k < DIV_STEPS; k++) begin
            rem_in = (k == 0) ? 32'd0 : r_rem[k-1];
            quo_in = (k == 0) ? i_num : r_quo[k-1];
            den_in = (k == 0) ? i_den : r_den[k-1];
            sh     = {rem_in, quo_in[31]};
            diff   = sh - {1'b0, den_in};
            n_den[k] = den_in;
            if (!diff[32]) begin
                n_rem[k] = diff[31:0];
                n_quo[k] = {quo_in[30:0], 1'b1};
            end else begin
                n_rem[k] = sh[31:0];
                n_quo[k] = {quo_in[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STEPS; k++) begin
            r_rem[k] <= n_rem[k];
            r_quo[k] <= n_quo[k];
            r_den[k] <= n_den[k];
        end
    end

    assign o_quo = r_quo[DIV_STEPS-1];

endmodule

>>> hdl/bsc_temp.sv
`timescale 1ns / 1ps

module bsc_temp
    import bsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cal        i_cal,
    input  logic        i_vld,
    input  logic [15:0] i_ut,
    input  logic [23:0] i_up_raw,
    output t_tbeat      o_beat
);

    logic        r1_v, r2_v, r3_v;
    logic [31:0] r1_d;
    logic [23:0] r1_up, r2_up, r3_up;
    logic [31:0] r2_m, r3_x1;
    logic [31:0] r3_num, r3_den;
    logic        r3_neg, r3_fault;
    logic [31:0] w_quo;
    logic [31:0] w_x1, w_div, w_num;

    logic        r_dv    [DIV_STEPS];
    logic        r_dneg  [DIV_STEPS];
    logic        r_dflt  [DIV_STEPS];
    logic [31:0] r_dx1   [DIV_STEPS];
    logic [23:0] r_dup   [DIV_STEPS];
    logic        r_bvld;
    logic        r_bflt;
    logic [31:0] r_bb5;
    logic [23:0] r_bup;

    assign w_x1  = asr(r2_m, 5'd15);
    assign w_div = w_x1 + i_cal.md;
    assign w_num = i_cal.mc << 11;

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            for (int k = 0; k < DIV_STEPS; k++) r_dv[k] <= 1'b0;
            r_bvld <= 1'b0;
        end else begin
            r1_v <= i_vld;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r_dv[0] <= r3_v;
            for (int k = 1; k < DIV_STEPS; k++) r_dv[k] <= r_dv[k-1];
            r_bvld <= r_dv[DIV_STEPS-1];
        end
    end

    // ut - ac6 and raw up shift, then times ac5, then operand magnitudes, signs and zero-divisor fault
    always_ff @(posedge i_clk) begin
        r1_d   <= zx16(i_ut) - i_cal.ac6;
        r1_up  <= 24'(i_up_raw >> (4'd8 - {2'b00, i_cal.oss}));
        r2_m   <= r1_d * i_cal.ac5;
        r2_up  <= r1_up;
        r3_x1  <= w_x1;
        r3_up  <= r2_up;
        r3_num <= w_num[31] ? (32'd0 - w_num) : w_num;
        r3_den <= w_div[31] ? (32'd0 - w_div) : w_div;
        r3_neg <= w_num[31] ^ w_div[31];
        r3_fault <= (w_div == 32'd0);
    end

    bsc_div u_div (
        .i_clk (i_clk),
        .i_num (r3_num),
        .i_den (r3_den),
        .o_quo (w_quo)
    );

    // sideband alongside the divider
    always_ff @(posedge i_clk) begin
        r_dneg[0] <= r3_neg;
        r_dflt[0] <= r3_fault;
        r_dx1[0]  <= r3_x1;
        r_dup[0]  <= r3_up;
        for (int k = 1; k < DIV_STEPS; k++) begin
            r_dneg[k] <= r_dneg[k-1];
            r_dflt[k] <= r_dflt[k-1];
            r_dx1[k]  <= r_dx1[k-1];
            r_dup[k]  <= r_dup[k-1];
        end
    end

    // b5 = x1 + signed quotient
    always_ff @(posedge i_clk) begin
        r_bflt <= r_dflt[DIV_STEPS-1];
        r_bup  <= r_dup[DIV_STEPS-1];
        r_bb5  <= r_dx1[DIV_STEPS-1] +
                  (r_dneg[DIV_STEPS-1] ? (32'd0 - w_quo) : w_quo);
    end

    assign o_beat = '{vld: r_bvld, fault: r_bflt, b5: r_bb5, up: r_bup};

endmodule

>>> hdl/bsc_press.sv
`timescale 1ns / 1ps

module bsc_press
    import bsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cal        i_cal,
    input  t_tbeat      i_beat,
    output logic        o_valid,
    output logic [15:0] o_temp,
    output logic [31:0] o_pres,
    output logic        o_fault
);

    localparam int NS = 8;  // stages ahead of the divider

    // control and pass-through per stage
    logic        r_v   [NS];
    logic        r_f   [NS];
    logic [15:0] r_t   [NS];
    logic [23:0] r_up  [NS];

    logic [31:0] r_b6;
    logic [31:0] r_sqm, r_a2, r_a3;
    logic [31:0] r_sq, r_x2a, r_x1c;
    logic [31:0] r_b2sq, r_b1sq, r4_x2a, r4_x1c;
    logic [31:0] r_x3, r_x3c;
    logic [31:0] r_b3, r_t4;
    logic [31:0] r_b4m, r_b7;
    logic [31:0] r_num, r_den;
    logic        r_big;
    logic [31:0] w_b5r, w_quo, w_b4, w_b3s;

    logic        r_dv  [DIV_STEPS];
    logic        r_df  [DIV_STEPS];
    logic        r_db  [DIV_STEPS];
    logic [15:0] r_dt  [DIV_STEPS];

    logic        r9_v, r10_v, r11_v, r_ov;
    logic        r9_f, r10_f, r11_f;
    logic [15:0] r9_t, r10_t, r11_t;
    logic [31:0] r_p, r10_p, r11_p;
    logic [31:0] r_x1p, r_x2p, r_x1, r_x2;
    logic [15:0] r_otemp;
    logic [31:0] r_opres;
    logic        r_ofault;

    assign w_b5r = asr(i_beat.b5 + C_TEMP_RND, 5'd4);
    assign w_b4  = r_b4m >> 15;
    assign w_b3s = (((i_cal.ac1 << 2) + r_x3) << i_cal.oss) + 32'd2;

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_v[k] <= 1'b0;
            for (int k = 0; k < DIV_STEPS; k++) r_dv[k] <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
            r11_v <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_v[0] <= i_beat.vld;
            for (int k = 1; k < NS; k++) r_v[k] <= r_v[k-1];
            r_dv[0] <= r_v[NS-1];
            for (int k = 1; k < DIV_STEPS; k++) r_dv[k] <= r_dv[k-1];
            r9_v  <= r_dv[DIV_STEPS-1];
            r10_v <= r9_v;
            r11_v <= r10_v;
            r_ov  <= r11_v;
        end
    end

    // pass-through fields ahead of the divider
    always_ff @(posedge i_clk) begin
        r_f[0]  <= i_beat.fault;
        r_t[0]  <= w_b5r[15:0];
        r_up[0] <= i_beat.up;
        for (int k = 1; k < NS; k++) begin
            r_f[k]  <= r_f[k-1];
            r_t[k]  <= r_t[k-1];
            r_up[k] <= r_up[k-1];
        end
    end

    // b6, products, b3, b4, b7 and the divider operands
    always_ff @(posedge i_clk) begin
        r_b6   <= i_beat.b5 - C_TEMP_OFS;
        r_sqm  <= r_b6 * r_b6;
        r_a2   <= i_cal.ac2 * r_b6;
        r_a3   <= i_cal.ac3 * r_b6;
        r_sq   <= asr(r_sqm, 5'd12);
        r_x2a  <= asr(r_a2, 5'd11);
        r_x1c  <= asr(r_a3, 5'd13);
        r_b2sq <= i_cal.b2 * r_sq;
        r_b1sq <= i_cal.b1 * r_sq;
        r4_x2a <= r_x2a;
        r4_x1c <= r_x1c;
        r_x3   <= asr(r_b2sq, 5'd11) + r4_x2a;
        r_x3c  <= asr(asr(r_b1sq, 5'd16) + r4_x1c + 32'd2, 5'd2);
        r_b3   <= asr(w_b3s, 5'd2);
        r_t4   <= r_x3c + C_B4_OFS;
        r_b4m  <= i_cal.ac4 * r_t4;
        r_b7   <= ({8'd0, r_up[5]} - r_b3) * (C_B7_SCALE >> i_cal.oss);
        r_den  <= w_b4;
        r_big  <= r_b7[31];
        r_num  <= r_b7[31] ? r_b7 : (r_b7 << 1);
    end

    // fault picks up a zero b4 at the last stage before the divider
    logic w_f8;
    assign w_f8 = r_f[NS-1];

    bsc_div u_div (
        .i_clk (i_clk),
        .i_num (r_num),
        .i_den (r_den),
        .o_quo (w_quo)
    );

    // sideband alongside the divider
    always_ff @(posedge i_clk) begin
        r_df[0] <= w_f8 | (r_den == 32'd0);
        r_db[0] <= r_big;
        r_dt[0] <= r_t[NS-1];
        for (int k = 1; k < DIV_STEPS; k++) begin
            r_df[k] <= r_df[k-1];
            r_db[k] <= r_db[k-1];
            r_dt[k] <= r_dt[k-1];
        end
    end

    // final pressure correction; a fault zeroes temperature and pressure
    always_ff @(posedge i_clk) begin
        r_p   <= r_db[DIV_STEPS-1] ? (w_quo << 1) : w_quo;
        r9_f  <= r_df[DIV_STEPS-1];
        r9_t  <= r_dt[DIV_STEPS-1];
        r_x1p <= asr(r_p, 5'd8) * asr(r_p, 5'd8);
        r_x2p <= r_p * C_P_K2;
        r10_p <= r_p;
        r10_f <= r9_f;
        r10_t <= r9_t;
        r_x1  <= asr(r_x1p * C_P_K1, 5'd16);
        r_x2  <= asr(r_x2p, 5'd16);
        r11_p <= r10_p;
        r11_f <= r10_f;
        r11_t <= r10_t;
        r_ofault <= r11_f;
        r_otemp  <= r11_f ? 16'd0 : r11_t;
        r_opres  <= r11_f ? 32'd0 : r11_p + asr(r_x1 + r_x2 + C_P_K3, 5'd4);
    end

    assign o_valid = r_ov;
    assign o_temp  = r_otemp;
    assign o_pres  = r_opres;
    assign o_fault = r_ofault;

endmodule

>>> hdl/bsc_checker.sv
`timescale 1ns / 1ps

module bsc_checker
    import bsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        o_busy,
    input  logic        o_valid,
    input  logic [15:0] o_temperature_tenths,
    input  logic [31:0] o_pressure_pa,
    input  logic        o_divide_fault
);

    // pipeline never holds off a command
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy) else $error("busy raised");

    // every result beat traces back to a start at the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, LATENCY)) else $error("result without start");

    // a fault beat carries zero results
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_fault) |-> (o_temperature_tenths == 16'd0 &&
        o_pressure_pa == 32'd0)) else $error("fault beat with data");

endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_start              (i_start),
    .o_busy               (o_busy),
    .o_valid              (o_valid),
    .o_temperature_tenths (o_temperature_tenths),
    .o_pressure_pa        (o_pressure_pa),
    .o_divide_fault       (o_divide_fault)
);
